// File: hdl/assert_macros.svh
// Assertion macros shared by the frame flip/gray RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ffg_pkg.sv
// Package for the frame flip/gray engine: sizes, codes, word types.
`default_nettype none

package ffg_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	localparam int CFG_W  = 9;                         // widest register
	localparam int WDIM_W = $clog2(MAX_WIDTH + 1);     // clamped width 1..MAX
	localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int TOT_W  = WDIM_W + HDIM_W;

	// register indexes
	localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd1;
	localparam logic [2:0] CFG_PIXEL_BYTES   = 3'd2;
	localparam logic [2:0] CFG_GRAY_ENABLE   = 3'd3;
	localparam logic [2:0] CFG_MIRROR_ENABLE = 3'd4;
	localparam logic [2:0] CFG_FLIP_ENABLE   = 3'd5;

	localparam logic [8:0] RST_FRAME_WIDTH  = 9'd256;
	localparam logic [8:0] RST_FRAME_HEIGHT = 9'd256;
	localparam logic [2:0] RST_PIXEL_BYTES  = 3'd3;
	localparam logic [2:0] PIXEL_BYTES_ALPHA = 3'd4;

	// word function codes
	localparam logic FUNC_STORE = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	// floor(s/3) == (s*683) >> 11 for every s below 2048
	localparam logic [10:0] GRAY_MUL   = 11'd683;
	localparam int          GRAY_SHIFT = 11;

	typedef struct packed {
		logic       func;
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
		logic [7:0] chan3;
	} req_word_t;

	typedef struct packed {
		logic [7:0] out0;
		logic [7:0] out1;
		logic [7:0] out2;
		logic [7:0] out3;
		logic       frame_end;
	} rsp_word_t;

	// per-fetch controls riding along with the store read
	typedef struct packed {
		logic last;
		logic gray;
		logic alpha;
	} fetch_ctl_t;

	function automatic logic [WDIM_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
		int unsigned t;
		t = v;
		if (t == 0) t = 1;
		else if (t > MAX_WIDTH) t = MAX_WIDTH;
		return WDIM_W'(t);
	endfunction

	function automatic logic [HDIM_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
		int unsigned t;
		t = v;
		if (t == 0) t = 1;
		else if (t > MAX_HEIGHT) t = MAX_HEIGHT;
		return HDIM_W'(t);
	endfunction

endpackage

`default_nettype wire

// File: hdl/ffg_gray.sv
// Output pixel shaping: grayscale average and alpha select.
`default_nettype none

module ffg_gray import ffg_pkg::*; (
	input  wire logic [31:0] pixel,
	input  wire fetch_ctl_t  ctl,
	output rsp_word_t        word
);

	logic [9:0]  sum;
	logic [20:0] prod;
	logic [7:0]  g;

	assign sum  = 10'(pixel[7:0]) + 10'(pixel[15:8]) + 10'(pixel[23:16]);
	assign prod = 21'(sum) * 21'(GRAY_MUL);
	assign g    = prod[GRAY_SHIFT +: 8];

	always_comb begin
		word.out0      = ctl.gray ? g : pixel[7:0];
		word.out1      = ctl.gray ? g : pixel[15:8];
		word.out2      = ctl.gray ? g : pixel[23:16];
		word.out3      = ctl.alpha ? pixel[31:24] : 8'd0;
		word.frame_end = ctl.last;
	end

endmodule

`default_nettype wire

// File: hdl/frame_flip_gray_engine.sv
// Top level of the frame flip/gray engine: frame store, address counters, output stage.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------------
//  req     | in        | req_valid/req_stall  | req_word: func, chan0..chan3
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_word: out0..out3, frame_end
//  cfg     | in        | cfg_we               | cfg_index, cfg_data (9 bits)
//
// One word per cycle while req_stall is low: a store writes the single-port frame RAM in the
// cycle it is taken; a fetch reads it into the read register, and the read data is then shaped
// into the rsp register once that is free or draining. The RAM port is the only shared resource.
// Reset clears the counters, configuration and valid flags; the frame RAM and data registers are not cleared.
// req_stall rises only while a fetched pixel waits behind a stalled, full rsp register.
`default_nettype none

module frame_flip_gray_engine import ffg_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_word_t        req_word,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_word_t             rsp_word,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

`include "assert_macros.svh"

	// ---------------- configuration registers ----------------
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [2:0]       pixel_bytes_q;
	logic             gray_enable_q;
	logic             mirror_enable_q;
	logic             flip_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= RST_FRAME_WIDTH;
			frame_height_q  <= RST_FRAME_HEIGHT;
			pixel_bytes_q   <= RST_PIXEL_BYTES;
			gray_enable_q   <= 1'b0;
			mirror_enable_q <= 1'b0;
			flip_enable_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data;
				CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data;
				CFG_PIXEL_BYTES:   pixel_bytes_q   <= cfg_data[2:0];
				CFG_GRAY_ENABLE:   gray_enable_q   <= cfg_data[0];
				CFG_MIRROR_ENABLE: mirror_enable_q <= cfg_data[0];
				CFG_FLIP_ENABLE:   flip_enable_q   <= cfg_data[0];
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	// out-of-range dimensions clamp to 1..MAX
	logic [WDIM_W-1:0] w, w_m1;
	logic [HDIM_W-1:0] h, h_m1;
	logic [TOT_W-1:0]  total;

	assign w     = clamp_w(frame_width_q);
	assign h     = clamp_h(frame_height_q);
	assign w_m1  = w - WDIM_W'(1);
	assign h_m1  = h - HDIM_W'(1);
	assign total = w * h;

	// ---------------- handshake ----------------
	logic       req_acc, is_fetch, is_store;
	logic       s1_valid_q, s1_adv;
	fetch_ctl_t s1_ctl_q;
	logic       rsp_valid_q;

	// the fetch in flight moves on whenever the rsp register is free or draining
	assign s1_adv    = !rsp_valid_q || !rsp_stall;
	assign req_stall = s1_valid_q && !s1_adv;
	assign req_acc   = req_valid && !req_stall;
	assign is_fetch  = req_acc && (req_word.func == FUNC_FETCH);
	assign is_store  = req_acc && (req_word.func == FUNC_STORE);

	// ---------------- store address ----------------
	logic [ADDR_W-1:0] store_count_q, sc_e, sc_next;
	logic [TOT_W-1:0]  sc_inc;

	// count left past the frame by a shrink restarts at the first pixel
	assign sc_e    = (TOT_W'(store_count_q) >= total) ? '0 : store_count_q;
	assign sc_inc  = TOT_W'(sc_e) + TOT_W'(1);
	assign sc_next = (sc_inc >= total) ? '0 : ADDR_W'(sc_inc);

	// ---------------- fetch address ----------------
	logic [ROW_W-1:0] out_row_q, row_e, row_next, r;
	logic [COL_W-1:0] out_col_q, col_e, col_next, c;
	logic             pos_out, last_col, last_row;
	logic [ROW_W+WDIM_W-1:0] rw;
	logic [ADDR_W-1:0] fetch_addr;

	assign pos_out  = (HDIM_W'(out_row_q) >= h) || (WDIM_W'(out_col_q) >= w);
	assign row_e    = pos_out ? '0 : out_row_q;
	assign col_e    = pos_out ? '0 : out_col_q;
	assign last_col = (WDIM_W'(col_e) == w_m1);
	assign last_row = (HDIM_W'(row_e) == h_m1);

	assign col_next = last_col ? '0 : col_e + COL_W'(1);
	assign row_next = !last_col ? row_e : (last_row ? '0 : row_e + ROW_W'(1));

	// flip reverses rows only, mirror reverses columns within a row
	assign r = flip_enable_q   ? ROW_W'(h_m1 - HDIM_W'(row_e)) : row_e;
	assign c = mirror_enable_q ? COL_W'(w_m1 - WDIM_W'(col_e)) : col_e;
	assign rw = r * w;
	assign fetch_addr = ADDR_W'(rw) + ADDR_W'(c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_count_q <= '0;
			out_row_q     <= '0;
			out_col_q     <= '0;
		end else begin
			if (is_store) store_count_q <= sc_next;
			if (is_fetch) begin
				out_row_q <= row_next;
				out_col_q <= col_next;
			end
		end
	end

	// ---------------- frame RAM, single port ----------------
	logic [31:0] pixel_store [STORE_DEPTH];
	logic [31:0] rd_s1;
	logic [ADDR_W-1:0] ram_addr;

	assign ram_addr = is_store ? sc_e : fetch_addr;

	// read data only reloads on a fetch, so it holds while the output is stalled
	always_ff @(posedge clk) begin
		if (is_store)
			pixel_store[ram_addr] <= {req_word.chan3, req_word.chan2,
			                          req_word.chan1, req_word.chan0};
		if (is_fetch)
			rd_s1 <= pixel_store[ram_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (is_fetch) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_fetch) begin
			s1_ctl_q.last  <= last_col && last_row;
			s1_ctl_q.gray  <= gray_enable_q;
			s1_ctl_q.alpha <= (pixel_bytes_q == PIXEL_BYTES_ALPHA);
		end
	end

	// ---------------- output stage ----------------
	rsp_word_t shaped;
	rsp_word_t rsp_word_q;

	ffg_gray u_gray (
		.pixel (rd_s1),
		.ctl   (s1_ctl_q),
		.word  (shaped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_valid_q && s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) rsp_word_q <= shaped;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	// ---------------- checks ----------------
	`ASSERT_ALWAYS(a_blocked_fetch_stalls, !(s1_valid_q && !s1_adv) || req_stall, "fetch in flight overrun")
	`ASSERT_NEXT(a_fetch_enters_s1, is_fetch, s1_valid_q, "accepted fetch lost before read stage")
	`ASSERT_NEXT(a_s1_reaches_rsp, s1_valid_q && s1_adv, rsp_valid, "read data did not reach output")
	`ASSERT_ALWAYS(a_no_dual_access, !(is_store && is_fetch), "store and fetch in one cycle")

endmodule

`default_nettype wire

// File: test/frame_flip_gray_engine_test.sv
// Self-checking testbench for the frame flip/gray engine: stores, mirrored/flipped fetches, gray.
`timescale 1ns / 100ps

module frame_flip_gray_engine_test import ffg_pkg::*; ();

	// indexes past the last register; writes there must change nothing
	localparam logic [2:0] CFG_UNMAPPED_LO = 3'd6;
	localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 180;
	localparam int IDLE_PCT = 12;
	// a store leaves nothing to wait for, a fetch passes the read and rsp registers; pad a little
	localparam int DRAIN_CYCLES = 4;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_word_t        req_word = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_word_t        rsp_word;
	logic             cfg_we = 1'b0;
	logic [2:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	frame_flip_gray_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the engine: frame contents, counters and registers.
	// frame_written keeps track of which entries hold data, so that no
	// fetch ever lands on an entry the RAM has never seen.
	// ------------------------------------------------------------------
	logic [31:0]      frame_mem [STORE_DEPTH];
	bit               frame_written [STORE_DEPTH];
	int unsigned      store_pos = 0;
	int unsigned      fetch_row = 0;
	int unsigned      fetch_col = 0;
	logic [CFG_W-1:0] width_reg = RST_FRAME_WIDTH;
	logic [CFG_W-1:0] height_reg = RST_FRAME_HEIGHT;
	logic [2:0]       bytes_reg = RST_PIXEL_BYTES;
	logic             gray_reg = 1'b0;
	logic             mirror_reg = 1'b0;
	logic             flip_reg = 1'b0;

	rsp_word_t   expected_pixels [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          steady = 1'b0;   // high: neither side idles

	// 0 reads as 1, anything past the frame maximum reads as that maximum
	function automatic int unsigned fit_dim(input logic [CFG_W-1:0] v, input int unsigned limit);
		if (v == '0)
			return 1;
		if (v > limit)
			return limit;
		return 32'(v);
	endfunction

	function automatic int unsigned frame_cols();
		return fit_dim(width_reg, MAX_WIDTH);
	endfunction

	function automatic int unsigned frame_rows();
		return fit_dim(height_reg, MAX_HEIGHT);
	endfunction

	// RAM entry the next fetch reads, counting the restart after a shrink
	function automatic int unsigned fetch_target();
		int unsigned w, h, row, col, r, c;
		w = frame_cols();
		h = frame_rows();
		row = fetch_row;
		col = fetch_col;
		if (row >= h || col >= w) begin
			row = 0;
			col = 0;
		end
		r = flip_reg ? (h - 1 - row) : row;
		c = mirror_reg ? (w - 1 - col) : col;
		return (r * w + c) % STORE_DEPTH;
	endfunction

	function automatic void apply_cfg(input logic [2:0] idx, input logic [CFG_W-1:0] d);
		case (idx)
			CFG_FRAME_WIDTH: width_reg = d;
			CFG_FRAME_HEIGHT: height_reg = d;
			CFG_PIXEL_BYTES: bytes_reg = d[2:0];
			CFG_GRAY_ENABLE: gray_reg = d[0];
			CFG_MIRROR_ENABLE: mirror_reg = d[0];
			CFG_FLIP_ENABLE: flip_reg = d[0];
			default: ;
		endcase
	endfunction

	function automatic void store_pixel(input req_word_t w);
		int unsigned total;
		total = frame_cols() * frame_rows();
		if (store_pos >= total)
			store_pos = 0;
		frame_mem[store_pos] = {w.chan3, w.chan2, w.chan1, w.chan0};
		frame_written[store_pos] = 1'b1;
		store_pos++;
		if (store_pos >= total)
			store_pos = 0;
	endfunction

	// work out the shaped pixel a fetch returns and queue it
	function automatic void fetch_pixel();
		int unsigned w, h, gray_sum;
		logic [31:0] px;
		rsp_word_t   shaped;
		w = frame_cols();
		h = frame_rows();
		if (fetch_row >= h || fetch_col >= w) begin
			fetch_row = 0;
			fetch_col = 0;
		end
		px = frame_mem[fetch_target()];
		shaped.out0 = px[7:0];
		shaped.out1 = px[15:8];
		shaped.out2 = px[23:16];
		if (gray_reg) begin
			gray_sum = px[7:0] + px[15:8] + px[23:16];
			shaped.out0 = 8'(gray_sum / 3);
			shaped.out1 = shaped.out0;
			shaped.out2 = shaped.out0;
		end
		// alpha is always stored, but only shown in four-byte mode
		shaped.out3 = (bytes_reg == PIXEL_BYTES_ALPHA) ? px[31:24] : 8'd0;
		shaped.frame_end = (fetch_row == h - 1) && (fetch_col == w - 1);
		expected_pixels.push_back(shaped);
		fetch_col++;
		if (fetch_col >= w) begin
			fetch_col = 0;
			fetch_row++;
			if (fetch_row >= h)
				fetch_row = 0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// bytes lean toward the all-zero and all-one corners
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic req_word_t random_word(input logic func);
		req_word_t w;
		w.func = func;
		w.chan0 = pick_byte();
		w.chan1 = pick_byte();
		w.chan2 = pick_byte();
		w.chan3 = pick_byte();
		return w;
	endfunction

	// Offer one word and hold it until taken. Valid stays high straight
	// into the next word unless an idle gap is drawn.
	task automatic send_word(input req_word_t w);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (w.func == FUNC_STORE)
			store_pixel(w);
		else
			fetch_pixel();
	endtask

	// Stop offering, let every queued result come home, then let the
	// pipe run empty so a register write cannot hit a word in flight.
	task automatic settle();
		req_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller drops it after the last write
	task automatic cfg_write(input logic [2:0] idx, input logic [CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		apply_cfg(idx, d);
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic [CFG_W-1:0] bytes, input logic [CFG_W-1:0] gray,
			input logic [CFG_W-1:0] mirror, input logic [CFG_W-1:0] flip);
		settle();
		cfg_write(CFG_FRAME_WIDTH, w);
		cfg_write(CFG_FRAME_HEIGHT, h);
		cfg_write(CFG_PIXEL_BYTES, bytes);
		cfg_write(CFG_GRAY_ENABLE, gray);
		cfg_write(CFG_MIRROR_ENABLE, mirror);
		cfg_write(CFG_FLIP_ENABLE, flip);
		if ($urandom_range(0, 3) == 0)
			cfg_write($urandom_range(0, 1) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO,
				9'($urandom_range(0, 511)));
		cfg_we <= 1'b0;
	endtask

	// Mixed stores and fetches. A fetch is only drawn when the pixel it
	// would read has been written; otherwise the slot becomes a store.
	task automatic run_items(input int n, input int fetch_pct);
		bit want_fetch;
		for (int k = 0; k < n; k++) begin
			want_fetch = ($urandom_range(0, 99) < fetch_pct) && frame_written[fetch_target()];
			send_word(random_word(want_fetch ? FUNC_FETCH : FUNC_STORE));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset frame (256x256, three bytes, no transforms): corner bytes go
	// in at the first raster slots and come straight back; alpha is stored
	// but must read as zero.
	task automatic test_reset_frame();
		logic [31:0] corner_px [5];
		req_word_t   w;
		corner_px = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h55AA_55AA, 32'hAA55_AA55, 32'hFE7F_8001};
		for (int i = 0; i < 5; i++) begin
			w.func = FUNC_STORE;
			{w.chan3, w.chan2, w.chan1, w.chan0} = corner_px[i];
			send_word(w);
		end
		for (int i = 0; i < 5; i++)
			send_word(random_word(FUNC_FETCH));
	endtask

	// Shrink to 2x2: both counters sit outside the new frame and restart.
	// Gray on the largest sum and on a sum that truncates to zero, alpha
	// shown, mirror and flip together, then a wrap past the frame end.
	task automatic test_shrink_gray();
		logic [31:0] quad_px [4];
		req_word_t   w;
		quad_px = '{32'h80FF_FFFF, 32'h00FE_FFFF, 32'hFF00_0000, 32'h7F00_0101};
		set_frame(9'd2, 9'd2, 9'(PIXEL_BYTES_ALPHA), 9'd1, 9'd1, 9'd1);
		for (int i = 0; i < 4; i++) begin
			w.func = FUNC_STORE;
			{w.chan3, w.chan2, w.chan1, w.chan0} = quad_px[i];
			send_word(w);
		end
		for (int i = 0; i < 5; i++)
			send_word(random_word(FUNC_FETCH));
	endtask

	// Widest row (width written past the maximum, one row), then the
	// tallest column (width 0, height at the maximum) over the same entries.
	task automatic test_extreme_dims();
		set_frame(9'd511, 9'd1, 9'($urandom_range(0, 7)), 9'($urandom_range(0, 511)), 9'd1,
			9'($urandom_range(0, 511)));
		run_items(MAX_WIDTH, 0);
		run_items(MAX_WIDTH + 1, 100);
		set_frame(9'd0, 9'(MAX_HEIGHT), 9'($urandom_range(0, 7)), 9'($urandom_range(0, 511)),
			9'($urandom_range(0, 511)), 9'd1);
		run_items(40, 90);
	endtask

	// Random frames, mostly small; now and then a zero or oversized side.
	task automatic test_random();
		int sent;
		int n;
		logic [CFG_W-1:0] w, h;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (sent >= 60 && sent < 150);
			case ($urandom_range(0, 19))
				0: begin
					w = '0;
					h = 9'($urandom_range(1, 6));
				end
				1: begin
					w = 9'd1;
					h = 9'($urandom_range(257, 511));
				end
				2: begin
					w = 9'($urandom_range(257, 511));
					h = 9'($urandom_range(0, 1));
				end
				default: begin
					w = 9'($urandom_range(1, 10));
					h = 9'($urandom_range(1, 10));
				end
			endcase
			set_frame(w, h, 9'($urandom_range(0, 7)), 9'($urandom_range(0, 511)),
				9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
			n = $urandom_range(30, 90);
			run_items(n, $urandom_range(25, 75));
			sent += n;
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: random stall, and the field-by-field check
	// ------------------------------------------------------------------
	always @(posedge clk)
		rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

	always @(posedge clk) begin : check_results
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("result word with nothing expected: %h", rsp_word);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (rsp_word.out0 !== want.out0) begin
					$error("out0: expected %0d, got %0d", want.out0, rsp_word.out0);
					mismatch_count++;
				end
				if (rsp_word.out1 !== want.out1) begin
					$error("out1: expected %0d, got %0d", want.out1, rsp_word.out1);
					mismatch_count++;
				end
				if (rsp_word.out2 !== want.out2) begin
					$error("out2: expected %0d, got %0d", want.out2, rsp_word.out2);
					mismatch_count++;
				end
				if (rsp_word.out3 !== want.out3) begin
					$error("out3: expected %0d, got %0d", want.out3, rsp_word.out3);
					mismatch_count++;
				end
				if (rsp_word.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, got %0d", want.frame_end,
						rsp_word.frame_end);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_frame();
		test_shrink_gray();
		test_extreme_dims();
		test_random();
		settle();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
